// ----- rtl/core/dns_response_address_parser_defines.svh -----
// Assertion macros for the DNS response address parser
`ifndef DNS_RESPONSE_ADDRESS_PARSER_DEFINES_SVH
`define DNS_RESPONSE_ADDRESS_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define DRAP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DRAP_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DRAP_ASSERT(label, clk, rst_n, prop, msg)
`define DRAP_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ----- rtl/core/drap_pkg.sv -----
// Types and constants for the DNS response address parser
package drap_pkg;
    localparam logic [7:0] PTR_MASK = 8'hC0;
    localparam int HEADER_BYTES = 12;
    localparam int FIXED_BYTES = 10;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_SHORT = 3'd1;
    localparam logic [2:0] ST_BADID = 3'd2;
    localparam logic [2:0] ST_NOANS = 3'd3;
    localparam logic [2:0] ST_QERR = 3'd4;
    localparam logic [2:0] ST_TRUNC = 3'd5;

    typedef enum logic [8:0] {
        PH_HDR   = 9'b000000001,
        PH_QNAME = 9'b000000010,
        PH_QSKIP = 9'b000000100,
        PH_ANAME = 9'b000001000,
        PH_AFIX  = 9'b000010000,
        PH_ADATA = 9'b000100000,
        PH_OK    = 9'b001000000,
        PH_BADID = 9'b010000000,
        PH_NOANS = 9'b100000000
    } t_phase;

    typedef struct packed {
        logic        kind;
        logic [31:0] address;
        logic [2:0]  status;
        logic [5:0]  found_count;
        logic        last;
    } t_result;
endpackage

// ----- rtl/core/drap_if.sv -----
// Valid/ready channel interfaces for bytes and results
interface drap_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface drap_result_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [31:0] address;
    logic [2:0]  status;
    logic [5:0]  found_count;
    logic        last_result;
    modport source (output valid, output result_kind, output address, output status,
                    output found_count, output last_result, input ready);
    modport sink (input valid, input result_kind, input address, input status,
                  input found_count, input last_result, output ready);
endinterface

// ----- rtl/core/drap_front.sv -----
// Parser front: walks the message, up to two results per byte beat
module drap_front import drap_pkg::*; #(
    parameter int MAX_MESSAGE_BYTES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic [15:0] i_match_id,
    output logic        o_addr_valid,
    output t_result     o_addr,
    output logic        o_stat_valid,
    output t_result     o_stat
);
    localparam int OW = $clog2(MAX_MESSAGE_BYTES + 1);

    t_phase      r_phase, n_phase;
    logic [OW-1:0] r_off, n_off;
    logic [3:0]  r_fidx, n_fidx;
    logic [15:0] r_mid, n_mid, r_ql, n_ql, r_al, n_al, r_skip, n_skip;
    logic [15:0] r_rt, n_rt, r_rc, n_rc, r_dl, n_dl;
    logic [31:0] r_acc, n_acc;
    logic [5:0]  r_found, n_found;
    logic        is_a;
    logic [2:0]  fstat;

    assign is_a = (n_rt == 16'd1) && (n_rc == 16'd1) && (n_dl == 16'd4);

    always_comb begin
        n_phase = r_phase; n_off = r_off; n_fidx = r_fidx; n_mid = r_mid;
        n_ql = r_ql; n_al = r_al; n_skip = r_skip; n_rt = r_rt; n_rc = r_rc;
        n_dl = r_dl; n_acc = r_acc; n_found = r_found;
        o_addr_valid = 1'b0;
        o_addr = '0;
        if (r_off < OW'(MAX_MESSAGE_BYTES)) begin
            n_off = r_off + 1'b1;
            unique case (r_phase)
                PH_HDR: begin
                    if (r_off < OW'(2)) n_mid = {r_mid[7:0], i_byte};
                    else if (r_off == OW'(4) || r_off == OW'(5)) n_ql = {r_ql[7:0], i_byte};
                    else if (r_off == OW'(6) || r_off == OW'(7)) n_al = {r_al[7:0], i_byte};
                    if (r_off == OW'(HEADER_BYTES - 1)) begin
                        n_skip = '0;
                        if (r_mid != i_match_id) n_phase = PH_BADID;
                        else if (r_al == '0) n_phase = PH_NOANS;
                        else n_phase = (r_ql != '0) ? PH_QNAME : PH_ANAME;
                    end
                end
                PH_QNAME, PH_ANAME: begin
                    if (r_skip != '0) begin
                        n_skip = r_skip - 1'b1;
                    end else if ((i_byte & PTR_MASK) == PTR_MASK || i_byte == '0) begin
                        if (r_phase == PH_QNAME) begin
                            n_ql = r_ql - 1'b1;
                            n_skip = (i_byte != '0) ? 16'd5 : 16'd4;
                            n_phase = PH_QSKIP;
                        end else begin
                            n_skip = (i_byte != '0) ? 16'd1 : 16'd0;
                            n_fidx = '0;
                            n_phase = PH_AFIX;
                        end
                    end else begin
                        n_skip = {8'd0, i_byte};
                    end
                end
                PH_QSKIP: begin
                    if (r_skip != '0) n_skip = r_skip - 1'b1;
                    if (n_skip == '0) n_phase = (r_ql != '0) ? PH_QNAME : PH_ANAME;
                end
                PH_AFIX: begin
                    if (r_skip != '0) begin
                        n_skip = r_skip - 1'b1;
                    end else begin
                        if (r_fidx < 4'd2) n_rt = {r_rt[7:0], i_byte};
                        else if (r_fidx < 4'd4) n_rc = {r_rc[7:0], i_byte};
                        else if (r_fidx >= 4'd8) n_dl = {r_dl[7:0], i_byte};
                        n_fidx = r_fidx + 1'b1;
                        if (n_fidx >= 4'(FIXED_BYTES)) begin
                            n_fidx = '0;
                            n_al = r_al - 1'b1;
                            n_acc = '0;
                            if (n_dl == '0) begin
                                n_skip = '0;
                                n_phase = (n_al != '0) ? PH_ANAME : PH_OK;
                            end else begin
                                n_skip = n_dl;
                                n_phase = PH_ADATA;
                            end
                        end
                    end
                end
                PH_ADATA: begin
                    n_acc = {r_acc[23:0], i_byte};
                    if (r_skip != '0) n_skip = r_skip - 1'b1;
                    if (n_skip == '0) begin
                        if (is_a) begin
                            if (r_found != 6'd63) n_found = r_found + 1'b1;
                            o_addr_valid = 1'b1;
                            o_addr.address = n_acc;
                            o_addr.found_count = n_found;
                        end
                        n_phase = (r_al != '0) ? PH_ANAME : PH_OK;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        case (n_phase)
            PH_HDR: fstat = ST_SHORT;
            PH_QNAME: fstat = ST_QERR;
            PH_QSKIP: fstat = (n_ql != '0) ? ST_QERR : ST_TRUNC;
            PH_ADATA: fstat = (is_a || n_al != '0) ? ST_TRUNC : ST_OK;
            PH_OK: fstat = ST_OK;
            PH_BADID: fstat = ST_BADID;
            PH_NOANS: fstat = ST_NOANS;
            default: fstat = ST_TRUNC;
        endcase
        o_stat_valid = i_last;
        o_stat.kind = 1'b1;
        o_stat.address = '0;
        o_stat.status = fstat;
        o_stat.found_count = n_found;
        o_stat.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_phase <= PH_HDR; r_off <= '0; r_fidx <= '0; r_mid <= '0; r_ql <= '0;
            r_al <= '0; r_skip <= '0; r_rt <= '0; r_rc <= '0; r_dl <= '0;
            r_acc <= '0; r_found <= '0;
        end else if (i_step) begin
            r_phase <= n_phase; r_off <= n_off; r_fidx <= n_fidx; r_mid <= n_mid;
            r_ql <= n_ql; r_al <= n_al; r_skip <= n_skip; r_rt <= n_rt; r_rc <= n_rc;
            r_dl <= n_dl; r_acc <= n_acc; r_found <= n_found;
        end
    end
endmodule

// ----- rtl/core/drap_queue.sv -----
// Result queue between parser front and output port, two writes per beat
module drap_queue import drap_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr0,
    input  t_result i_d0,
    input  logic    i_wr1,
    input  t_result i_d1,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_q,
    input  logic    i_pop
);
    localparam int DEPTH = 4;
    t_result     r_mem [DEPTH];
    logic [1:0]  r_rd, r_wr;
    logic [2:0]  r_cnt;
    logic [1:0]  nwr;
    logic        pop;

    assign pop = i_pop && (r_cnt != '0);
    assign nwr = {1'b0, i_wr0} + {1'b0, i_wr1};
    assign o_room = (r_cnt <= 3'(DEPTH - 2));
    assign o_valid = (r_cnt != '0);
    assign o_q = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_wr0) r_mem[r_wr] <= i_d0;
        if (i_wr1) r_mem[i_wr0 ? r_wr + 2'd1 : r_wr] <= i_d1;
        if (!i_rst_n) begin
            r_rd <= '0; r_wr <= '0; r_cnt <= '0;
        end else begin
            r_wr <= r_wr + nwr;
            r_rd <= r_rd + {1'b0, pop};
            r_cnt <= r_cnt + {1'b0, nwr} - {2'b0, pop};
        end
    end
endmodule

// ----- rtl/core/dns_response_address_parser.sv -----
// Top level of the DNS response address parser
// Results: each result is written into the result queue on the byte beat that causes it.
// Throughput: one byte per cycle; input stalls only when the four-entry result
// queue holds more than two results not yet taken.
// Reset: synchronous active low; clears parse state and queue, match ID to 0x1234.
`include "dns_response_address_parser_defines.svh"
module dns_response_address_parser import drap_pkg::*; #(
    parameter int MAX_MESSAGE_BYTES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    drap_byte_if.sink   i_in,
    drap_result_if.source o_out
);
    logic [15:0] r_match_id;
    logic        step, av, sv, room;
    t_result     ad, sd, q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_match_id <= 16'h1234;
        else if (i_cfg_we) r_match_id <= i_cfg_wdata;
    end

    assign i_in.ready = room;
    assign step = i_in.valid && room;

    drap_front #(.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)) u_front (
        .i_clk, .i_rst_n, .i_step(step), .i_byte(i_in.data_byte), .i_last(i_in.last_byte),
        .i_match_id(r_match_id), .o_addr_valid(av), .o_addr(ad),
        .o_stat_valid(sv), .o_stat(sd)
    );

    drap_queue u_queue (
        .i_clk, .i_rst_n, .i_wr0(step && av), .i_d0(ad), .i_wr1(step && sv), .i_d1(sd),
        .o_room(room), .o_valid(o_out.valid), .o_q(q), .i_pop(o_out.ready)
    );

    assign o_out.result_kind = q.kind;
    assign o_out.address = q.address;
    assign o_out.status = q.status;
    assign o_out.found_count = q.found_count;
    assign o_out.last_result = q.last;

    `DRAP_ASSERT(a_stall_hold, i_clk, i_rst_n, (o_out.valid && !o_out.ready) |=> o_out.valid, "result lost")
    `DRAP_ASSERT(a_kind_last, i_clk, i_rst_n, o_out.valid |-> (o_out.result_kind == o_out.last_result), "kind and last disagree")
    `DRAP_ASSERT(a_addr_zero, i_clk, i_rst_n, (o_out.valid && o_out.result_kind) |-> (o_out.address == '0), "status carries address")
endmodule
